// ===== rtl/brft_pkg.sv =====
// Shared types and constants for the banked register file with timer 0.
`timescale 1ns / 1ps

package brft_pkg;

  // Geometry
  localparam int BANK_BYTES = 128;
  localparam int ADDR_W     = 7;
  localparam int MEM_DEPTH  = 2 * BANK_BYTES;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  // Item commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Special register addresses
  localparam logic [ADDR_W-1:0] ADDR_INDF   = 7'h00;
  localparam logic [ADDR_W-1:0] ADDR_TMR0   = 7'h01;
  localparam logic [ADDR_W-1:0] ADDR_PCL    = 7'h02;
  localparam logic [ADDR_W-1:0] ADDR_STATUS = 7'h03;
  localparam logic [ADDR_W-1:0] ADDR_FSR    = 7'h04;
  localparam logic [ADDR_W-1:0] ADDR_INTCON = 7'h0B;

  // Bit positions
  localparam int RP0_BIT  = 5;
  localparam int T0IF_BIT = 2;

  // Request to the general purpose byte store
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [MEM_AW-1:0] idx;
    logic [7:0]        wdata;
  } gpr_req_t;

endpackage

// ===== rtl/banked_register_file_with_timer0.sv =====
// Top level: banked register file with timer 0 and its stream interface.
`timescale 1ns / 1ps

// Two banks of BANK_BYTES bytes; STATUS bit 5 picks the bank. Each input item
// carries a command (in_tuser: read, write or timer tick) with address and
// data in in_tdata. Every item yields exactly one result item on out_*:
// the byte read (zero for other commands), STATUS, TMR0, the TMR0 overflow
// flag and the active bank, all as they stand after the item.
// Special registers (INDF, TMR0, OPTION, PCL, STATUS, FSR, INTCON) and the
// prescaler live in flops; the other bytes sit in a RAM with a registered
// read port.
// Writes, ticks and unused commands put their result in the output register;
// a read goes through the RAM read register first. A new item is taken every
// cycle for writes and ticks while the receiver keeps up; after a read the
// input is held off while the RAM read is pending.
// Reset clears the special registers, prescaler and all RAM valid bits, so the
// whole file reads zero at once; no clearing pass is needed.
// If the receiver stalls, the result waits in the output register and the
// input is held off only until that register is free.

module banked_register_file_with_timer0 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] address, [14:7] data, [15] zero
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [15:8] status_value, [23:16] timer_value,
  // [24] timer_flag, [25] active_bank, [31:26] zero
  output logic [31:0] out_tdata
);

  localparam int AW = brft_pkg::ADDR_W;

  logic [7:0] indf_r, tmr0_r, option_r, pcl_r, status_r, fsr_r, intcon_r, pre_r;
  logic [7:0] indf_nxt, tmr0_nxt, option_nxt, pcl_nxt, status_nxt, fsr_nxt;
  logic [7:0] intcon_nxt, pre_nxt;

  logic        rd_pend_r;
  logic        spec_sel_r;
  logic [7:0]  spec_rd_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic          acc;
  logic [1:0]    cmd;
  logic [AW-1:0] addr;
  logic [7:0]    wdat;
  logic          bank;
  logic [AW-1:0] wa;
  logic          wa_ok;
  logic          ra_ok;
  logic          spec_sel;
  logic [7:0]    spec_rd;
  logic [8:0]    pre_inc;
  logic [8:0]    pre_lim;
  logic [7:0]    gpr_byte;
  logic [7:0]    rd_byte;

  brft_pkg::gpr_req_t gpr_req;

  assign acc  = in_tvalid && in_tready;
  assign cmd  = in_tuser;
  assign addr = in_tdata[6:0];
  assign wdat = in_tdata[14:7];
  assign bank = status_r[brft_pkg::RP0_BIT];

  // Effective write address: address 0 goes through FSR
  assign wa    = (addr == brft_pkg::ADDR_INDF) ? fsr_r[AW-1:0] : addr;
  assign wa_ok = ({1'b0, wa} < (AW+1)'(brft_pkg::BANK_BYTES));
  assign ra_ok = ({1'b0, addr} < (AW+1)'(brft_pkg::BANK_BYTES));

  // Prescaler roll-over test: count + 1 >= 2^(PS+1)
  assign pre_inc = {1'b0, pre_r} + 9'd1;
  assign pre_lim = 9'd1 << ({1'b0, option_r[2:0]} + 4'd1);

  // Read mux for flop-held registers
  always_comb begin
    spec_sel = 1'b1;
    spec_rd  = 8'h00;
    unique case (addr)
      brft_pkg::ADDR_INDF:   spec_rd = indf_r;
      brft_pkg::ADDR_TMR0:   spec_rd = bank ? option_r : tmr0_r;
      brft_pkg::ADDR_PCL:    spec_rd = pcl_r;
      brft_pkg::ADDR_STATUS: spec_rd = status_r;
      brft_pkg::ADDR_FSR:    spec_rd = fsr_r;
      brft_pkg::ADDR_INTCON: spec_rd = intcon_r;
      default:               spec_sel = !ra_ok;  // out of bank reads zero
    endcase
  end

  // Next state of the special registers and the RAM request
  always_comb begin
    indf_nxt   = indf_r;
    tmr0_nxt   = tmr0_r;
    option_nxt = option_r;
    pcl_nxt    = pcl_r;
    status_nxt = status_r;
    fsr_nxt    = fsr_r;
    intcon_nxt = intcon_r;
    pre_nxt    = pre_r;
    gpr_req.wr    = 1'b0;
    gpr_req.rd    = 1'b0;
    gpr_req.idx   = brft_pkg::MEM_AW'(bank ? brft_pkg::BANK_BYTES : 0) +
                    brft_pkg::MEM_AW'(cmd == brft_pkg::CMD_READ ? addr : wa);
    gpr_req.wdata = wdat;
    if (acc) begin
      unique case (cmd)
        brft_pkg::CMD_READ: begin
          gpr_req.rd = !spec_sel;
        end
        brft_pkg::CMD_WRITE: begin
          if (wa_ok) begin
            unique case (wa)
              brft_pkg::ADDR_INDF:   indf_nxt = wdat;
              brft_pkg::ADDR_TMR0: begin
                if (bank) begin
                  option_nxt = wdat;
                end else begin
                  tmr0_nxt = wdat;
                  pre_nxt  = 8'h00;
                end
              end
              brft_pkg::ADDR_PCL:    pcl_nxt    = wdat;
              brft_pkg::ADDR_STATUS: status_nxt = wdat;
              brft_pkg::ADDR_FSR:    fsr_nxt    = wdat;
              brft_pkg::ADDR_INTCON: intcon_nxt = wdat;
              default:               gpr_req.wr = 1'b1;
            endcase
          end
        end
        brft_pkg::CMD_TICK: begin
          if (pre_inc >= pre_lim) begin
            pre_nxt  = 8'h00;
            tmr0_nxt = tmr0_r + 8'd1;
            if (tmr0_r == 8'hFF) begin
              intcon_nxt[brft_pkg::T0IF_BIT] = 1'b1;
            end
          end else begin
            pre_nxt = pre_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  brft_gpr u_gpr (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (gpr_req),
    .rd_byte (gpr_byte)
  );

  assign rd_byte = spec_sel_r ? spec_rd_r : gpr_byte;

  // Special registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indf_r   <= 8'h00;
      tmr0_r   <= 8'h00;
      option_r <= 8'h00;
      pcl_r    <= 8'h00;
      status_r <= 8'h00;
      fsr_r    <= 8'h00;
      intcon_r <= 8'h00;
      pre_r    <= 8'h00;
    end else begin
      indf_r   <= indf_nxt;
      tmr0_r   <= tmr0_nxt;
      option_r <= option_nxt;
      pcl_r    <= pcl_nxt;
      status_r <= status_nxt;
      fsr_r    <= fsr_nxt;
      intcon_r <= intcon_nxt;
      pre_r    <= pre_nxt;
    end
  end

  // Read in flight: hold the flop-side byte until the RAM answers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= acc && (cmd == brft_pkg::CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      spec_sel_r <= spec_sel;
      spec_rd_r  <= spec_rd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r || (acc && cmd != brft_pkg::CMD_READ)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_data_r <= {6'b0, bank, intcon_r[brft_pkg::T0IF_BIT], tmr0_r, status_r,
                     rd_byte};
    end else if (acc && cmd != brft_pkg::CMD_READ) begin
      out_data_r <= {6'b0, status_nxt[brft_pkg::RP0_BIT],
                     intcon_nxt[brft_pkg::T0IF_BIT], tmr0_nxt, status_nxt, 8'h00};
    end
  end

  assign in_tready  = !rd_pend_r && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A read always leaves a RAM cycle pending
  a_read_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cmd == brft_pkg::CMD_READ) |=> rd_pend_r)
    else $error("read accepted without pending RAM cycle");

  // The output register is free when a read result lands
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("read result would overwrite an unsent item");

  // No new item while a read is in flight
  a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !in_tready)
    else $error("input taken during pending read");

  // Reported bank agrees with reported STATUS
  a_bank_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[25] == out_data_r[13]))
    else $error("active bank differs from STATUS bit 5");

endmodule

// ===== rtl/brft_gpr.sv =====
// General purpose byte store: synchronous RAM with per-entry valid bits.
`timescale 1ns / 1ps

module brft_gpr (
  input  logic                clk,
  input  logic                rst_n,
  input  brft_pkg::gpr_req_t  req,
  output logic [7:0]          rd_byte
);

  logic [7:0]                   mem_r [brft_pkg::MEM_DEPTH];
  logic [brft_pkg::MEM_DEPTH-1:0] vld_r;
  logic [7:0]                   rd_q_r;
  logic                         rd_vld_r;

  // RAM array, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem_r[req.idx] <= req.wdata;
    end
    if (req.rd) begin
      rd_q_r <= mem_r[req.idx];
    end
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr) begin
        vld_r[req.idx] <= 1'b1;
      end
      if (req.rd) begin
        rd_vld_r <= vld_r[req.idx];
      end
    end
  end

  assign rd_byte = rd_vld_r ? rd_q_r : 8'h00;

endmodule

// ===== test/banked_register_file_with_timer0_tb.sv =====
// Self-checking testbench for the banked register file with timer 0.
`timescale 1ns / 1ps

module banked_register_file_with_timer0_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PS_BITS = 3;

  // One result item as the block should produce it
  typedef struct {
    logic [7:0] read_data;
    logic [7:0] status_value;
    logic [7:0] timer_value;
    logic       timer_flag;
    logic       active_bank;
  } regfile_result_t;

  // Mirror of the register file plus the queue of results still owed
  class regfile_scoreboard;
    logic [7:0] regs [brft_pkg::MEM_DEPTH];
    logic [7:0] prescale_cnt;
    regfile_result_t owed_q[$];
    int mismatches;
    int results_seen;
    int wraps;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      prescale_cnt = 8'h00;
      mismatches   = 0;
      results_seen = 0;
      wraps        = 0;
    endfunction

    function logic bank_sel();
      return regs[brft_pkg::ADDR_STATUS][brft_pkg::RP0_BIT];
    endfunction

    function void put_both(int a, logic [7:0] v);
      if (a < brft_pkg::BANK_BYTES) begin
        regs[a] = v;
        regs[brft_pkg::BANK_BYTES + a] = v;
      end
    endfunction

    function void write_direct(int a, logic [7:0] v);
      int base;
      base = bank_sel() ? brft_pkg::BANK_BYTES : 0;
      if (a >= brft_pkg::BANK_BYTES) return;
      if (a == brft_pkg::ADDR_TMR0) begin
        // TMR0 in bank 0, OPTION in bank 1
        if (base == 0) begin
          regs[brft_pkg::ADDR_TMR0] = v;
          prescale_cnt = 8'h00;
        end else begin
          regs[brft_pkg::BANK_BYTES + brft_pkg::ADDR_TMR0] = v;
        end
      end else if (a == brft_pkg::ADDR_PCL || a == brft_pkg::ADDR_STATUS ||
                   a == brft_pkg::ADDR_FSR || a == brft_pkg::ADDR_INTCON) begin
        put_both(a, v);
      end else begin
        regs[base + a] = v;
      end
    endfunction

    function void write_reg(int a, logic [7:0] v);
      int target;
      if (a == brft_pkg::ADDR_INDF) begin
        // indirect through FSR; FSR pointing at 0 stores INDF itself
        target = regs[brft_pkg::ADDR_FSR][brft_pkg::ADDR_W-1:0];
        if (target == brft_pkg::ADDR_INDF) put_both(brft_pkg::ADDR_INDF, v);
        else write_direct(target, v);
      end else begin
        write_direct(a, v);
      end
    endfunction

    function void timer_tick();
      int ps;
      int limit;
      ps = regs[brft_pkg::BANK_BYTES + brft_pkg::ADDR_TMR0][PS_BITS-1:0];
      limit = 1 << (ps + 1);
      if (int'(prescale_cnt) + 1 >= limit) begin
        prescale_cnt = 8'h00;
        if (regs[brft_pkg::ADDR_TMR0] == 8'hFF) begin
          regs[brft_pkg::ADDR_TMR0] = 8'h00;
          put_both(brft_pkg::ADDR_INTCON,
                   regs[brft_pkg::ADDR_INTCON] | (8'h01 << brft_pkg::T0IF_BIT));
          wraps++;
        end else begin
          regs[brft_pkg::ADDR_TMR0] = regs[brft_pkg::ADDR_TMR0] + 8'h01;
        end
      end else begin
        prescale_cnt = prescale_cnt + 8'h01;
      end
    endfunction

    // Apply an accepted input item and queue the result it owes
    function void note_item(logic [1:0] cmd, logic [6:0] addr, logic [7:0] data);
      regfile_result_t r;
      int base;
      r.read_data = 8'h00;
      case (cmd)
        brft_pkg::CMD_READ: begin
          base = bank_sel() ? brft_pkg::BANK_BYTES : 0;
          if (addr < brft_pkg::BANK_BYTES) r.read_data = regs[base + addr];
        end
        brft_pkg::CMD_WRITE: write_reg(addr, data);
        brft_pkg::CMD_TICK:  timer_tick();
        default: ;
      endcase
      r.status_value = regs[brft_pkg::ADDR_STATUS];
      r.timer_value  = regs[brft_pkg::ADDR_TMR0];
      r.timer_flag   = regs[brft_pkg::ADDR_INTCON][brft_pkg::T0IF_BIT];
      r.active_bank  = bank_sel();
      owed_q.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] e, logic [7:0] a);
      if (e !== a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        mismatches++;
      end
    endfunction

    function void check_result(logic [31:0] t);
      regfile_result_t e;
      results_seen++;
      if (owed_q.size() == 0) begin
        $error("result 0x%0h arrived with none expected", t);
        mismatches++;
        return;
      end
      e = owed_q.pop_front();
      compare("read_data", e.read_data, t[7:0]);
      compare("status_value", e.status_value, t[15:8]);
      compare("timer_value", e.timer_value, t[23:16]);
      compare("timer_flag", {7'd0, e.timer_flag}, {7'd0, t[24]});
      compare("active_bank", {7'd0, e.active_bank}, {7'd0, t[25]});
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  regfile_scoreboard sb;
  bit calm;
  int cycle_count;
  int stall_left;
  int n_items;
  int n_cmd [4];

  banked_register_file_with_timer0 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-length watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_result(out_tdata);
  end

  // Receiver back-pressure: mostly short stalls, a few long ones
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:69]:  out_tready = 1'b1;
          [70:96]: begin out_tready = 1'b0; stall_left = $urandom_range(0, 2); end
          default: begin out_tready = 1'b0; stall_left = $urandom_range(10, 40); end
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one item from a falling edge and hold it until taken
  task automatic send_item(logic [1:0] cmd, logic [6:0] addr, logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {1'b0, data, addr};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(cmd, addr, data);
    n_items++;
    n_cmd[cmd]++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [6:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return brft_pkg::ADDR_INDF;
      1: return brft_pkg::ADDR_TMR0;
      2: return brft_pkg::ADDR_PCL;
      3: return brft_pkg::ADDR_STATUS;
      4: return brft_pkg::ADDR_FSR;
      5: return brft_pkg::ADDR_INTCON;
      6, 7: return 7'($urandom_range(5, 15));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Fast prescale, TMR0 near wrap, then a run of ticks
  task automatic timer_burst();
    int n;
    if ($urandom_range(0, 1))
      send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_INTCON, 8'($urandom) & 8'hFB);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_STATUS, (8'($urandom) & 8'hDF) | 8'h20);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_TMR0,
              (8'($urandom) & 8'hF8) | 8'($urandom_range(0, 2)));
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_STATUS, 8'($urandom) & 8'hDF);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_TMR0, 8'($urandom_range(8'hF0, 8'hFF)));
    n = $urandom_range(4, 40);
    repeat (n) send_item(brft_pkg::CMD_TICK, 7'($urandom), 8'($urandom));
    send_item(brft_pkg::CMD_READ, brft_pkg::ADDR_INTCON, 8'($urandom));
  endtask

  // Point FSR somewhere, write through INDF and read the target back
  task automatic indirect_access();
    logic [7:0] ptr;
    ptr = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 15)) : 8'($urandom);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_FSR, ptr);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_INDF, 8'($urandom));
    send_item(brft_pkg::CMD_READ, ptr[6:0], 8'($urandom));
  endtask

  // Stimulus
  initial begin
    sb = new();
    calm = 1'b0;
    n_items = 0;
    foreach (n_cmd[i]) n_cmd[i] = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = brft_pkg::CMD_READ;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset contents, both banks, timer wrap, indirect, odd commands
    send_item(brft_pkg::CMD_READ, brft_pkg::ADDR_INDF, 8'h00);
    send_item(brft_pkg::CMD_READ, 7'h7F, 8'hFF);
    send_item(brft_pkg::CMD_WRITE, 7'h0C, 8'hFF);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_STATUS, 8'h20);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_TMR0, 8'h07);
    send_item(brft_pkg::CMD_WRITE, 7'h0C, 8'h55);
    send_item(brft_pkg::CMD_READ, 7'h0C, 8'h00);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_STATUS, 8'hDF);
    send_item(brft_pkg::CMD_READ, 7'h0C, 8'h00);
    // prescale 256, count up, then shrink to 2 so the next tick rolls over
    repeat (3) send_item(brft_pkg::CMD_TICK, 7'h00, 8'h00);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_STATUS, 8'h20);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_TMR0, 8'hF8);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_STATUS, 8'h00);
    send_item(brft_pkg::CMD_TICK, 7'h00, 8'h00);
    // TMR0 write clears the prescaler; wrap sets the flag
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_TMR0, 8'hFE);
    repeat (4) send_item(brft_pkg::CMD_TICK, 7'h7F, 8'hFF);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_FSR, 8'h00);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_INDF, 8'hA5);
    send_item(brft_pkg::CMD_READ, brft_pkg::ADDR_INDF, 8'h00);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_FSR, 8'h8C);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_INDF, 8'h3C);
    send_item(brft_pkg::CMD_READ, 7'h0C, 8'h00);
    send_item(CMD_UNUSED, 7'h7F, 8'hFF);
    send_item(brft_pkg::CMD_WRITE, brft_pkg::ADDR_INTCON, 8'h00);

    // Random: single items mixed with timer and indirect sequences
    while (n_items < RANDOM_ITEMS) begin
      calm = (n_items >= 400 && n_items < 550);
      if (n_items >= 800 && n_items < 810) drain_results();
      case ($urandom_range(0, 99)) inside
        [0:69]: begin
          case ($urandom_range(0, 19)) inside
            [0:6]:   send_item(brft_pkg::CMD_READ, pick_addr(), 8'($urandom));
            [7:13]:  send_item(brft_pkg::CMD_WRITE, pick_addr(), 8'($urandom));
            [14:18]: send_item(brft_pkg::CMD_TICK, 7'($urandom), 8'($urandom));
            default: send_item(CMD_UNUSED, 7'($urandom), 8'($urandom));
          endcase
        end
        [70:84]: timer_burst();
        default: indirect_access();
      endcase
    end

    // Wind down
    calm = 1'b0;
    in_tvalid = 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d items: %0d reads, %0d writes, %0d ticks, %0d unused commands",
             n_items, n_cmd[brft_pkg::CMD_READ], n_cmd[brft_pkg::CMD_WRITE],
             n_cmd[brft_pkg::CMD_TICK], n_cmd[CMD_UNUSED]);
    $display("Checked %0d results, saw %0d timer wraps, %0d mismatches",
             sb.results_seen, sb.wraps, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== banked_register_file_with_timer0.f =====
rtl/brft_pkg.sv
rtl/brft_gpr.sv
rtl/banked_register_file_with_timer0.sv
test/banked_register_file_with_timer0_tb.sv
